FILE: rtl/affb_pkg.sv
package affb_pkg;

	// Number format of every coordinate and matrix word.
	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;

	// Widths derived from the number format.
	localparam int OPND_WIDTH = VALUE_WIDTH + 1;          // centre and extent
	localparam int PROD_WIDTH = 2 * VALUE_WIDTH + 1;      // raw magnitude product
	localparam int RND_WIDTH  = PROD_WIDTH + 1 - FRACTION_BITS;
	localparam int QW         = 60;                       // clamped signed product
	localparam int CMP_WIDTH  = (RND_WIDTH > QW) ? RND_WIDTH : QW;
	localparam int SW         = QW + 3;                   // lane sums

	// Product magnitudes are held within this bound.
	localparam logic [63:0] PCLAMP = 64'd1 << 58;

	typedef logic signed [VALUE_WIDTH-1:0] word_t;
	typedef logic signed [OPND_WIDTH-1:0]  opnd_t;
	typedef logic signed [QW-1:0]          prod_t;
	typedef logic        [QW-2:0]          mag_t;
	typedef logic signed [SW-1:0]          sum_t;

	// Pipeline control that travels with a box.
	typedef struct packed {
		logic valid;
		logic unb;
	} ctl_t;

	// Item commands.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_BOX  = 1'b1;

	localparam word_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam word_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam word_t ONE  = word_t'(1) << FRACTION_BITS;

	// Rounding constant, one half in the product's fraction.
	localparam logic [PROD_WIDTH:0] HALF = (PROD_WIDTH+1)'(1) << (FRACTION_BITS - 1);

	// Saturate a wide lane result to the coordinate width.
	function automatic word_t sat(input sum_t v);
		word_t r;
		if (v > SW'(VMAX)) begin
			r = VMAX;
		end else if (v < SW'(VMIN)) begin
			r = VMIN;
		end else begin
			r = v[VALUE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/affb_in_if.sv
interface affb_in_if import affb_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  command;
	logic  [1:0] column;
	word_t a_x;
	word_t a_y;
	word_t a_z;
	word_t b_x;
	word_t b_y;
	word_t b_z;

	modport source (output valid, command, column, a_x, a_y, a_z, b_x, b_y, b_z,
		input ready);
	modport sink (input valid, command, column, a_x, a_y, a_z, b_x, b_y, b_z,
		output ready);
endinterface

FILE: rtl/affb_out_if.sv
interface affb_out_if import affb_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t world_min_x;
	word_t world_min_y;
	word_t world_min_z;
	word_t world_max_x;
	word_t world_max_y;
	word_t world_max_z;
	logic  unbounded;

	modport source (output valid, world_min_x, world_min_y, world_min_z,
		world_max_x, world_max_y, world_max_z, unbounded, input ready);
	modport sink (input valid, world_min_x, world_min_y, world_min_z,
		world_max_x, world_max_y, world_max_z, unbounded, output ready);
endinterface

FILE: rtl/affb_front.sv
module affb_front import affb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  logic       command,
	input  logic [1:0] column,
	input  word_t      a [3],
	input  word_t      b [3],
	output ctl_t       ctl_s2,
	output opnd_t      ctr_s2 [3],
	output opnd_t      ext_s2 [3],
	output word_t      mat [4][3]
);

	logic       valid_s1;
	logic       cmd_s1;
	logic [1:0] col_s1;
	word_t      a_s1 [3];
	word_t      b_s1 [3];
	word_t      mat_q [4][3];
	opnd_t      ctr_c [3];
	opnd_t      ext_c [3];
	opnd_t      sum_c [3];
	logic       unb_c;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= command;
			col_s1 <= column;
			a_s1   <= a;
			b_s1   <= b;
		end
	end

	// Centre, half extent and unbounded test of a box.
	always_comb begin
		unb_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = OPND_WIDTH'(a_s1[i]) + OPND_WIDTH'(b_s1[i]);
			ctr_c[i] = sum_c[i] >>> 1;
			ext_c[i] = OPND_WIDTH'(b_s1[i]) - ctr_c[i];
			if (a_s1[i] == VMIN || b_s1[i] == VMAX) begin
				unb_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= valid_s1 && (cmd_s1 == CMD_BOX);
			ctl_s2.unb   <= unb_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctr_s2 <= ctr_c;
			ext_s2 <= ext_c;
		end
	end

	// Matrix store. A load writes one column as it leaves the input register,
	// so a box sees every load that was accepted before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 3; r++) begin
					mat_q[c][r] <= (c == r) ? ONE : '0;
				end
			end
		end else if (en && valid_s1 && cmd_s1 == CMD_LOAD) begin
			for (int r = 0; r < 3; r++) begin
				mat_q[col_s1][r] <= a_s1[r];
			end
		end
	end

	assign mat = mat_q;

endmodule

FILE: rtl/affb_mulq.sv
module affb_mulq import affb_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t a,
	input  opnd_t b,
	output prod_t prod_s4,
	output mag_t  mag_s4
);

	logic [VALUE_WIDTH-1:0] mag_a;
	logic [OPND_WIDTH-1:0]  mag_b;
	logic [PROD_WIDTH-1:0]  prod_s3;
	logic                   neg_s3;
	logic [PROD_WIDTH:0]    rnd_sum;
	logic [CMP_WIDTH-1:0]   rnd_w;
	mag_t                   mag_c;

	// Sign and magnitude multiply.
	always_comb begin
		mag_a = a[VALUE_WIDTH-1] ? VALUE_WIDTH'(-a) : VALUE_WIDTH'(a);
		mag_b = b[OPND_WIDTH-1] ? OPND_WIDTH'(-b) : OPND_WIDTH'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_WIDTH'(mag_a) * PROD_WIDTH'(mag_b);
			neg_s3  <= a[VALUE_WIDTH-1] ^ b[OPND_WIDTH-1];
		end
	end

	// Round half away from zero, clamp the magnitude, then restore the sign.
	always_comb begin
		rnd_sum = {1'b0, prod_s3} + HALF;
		rnd_w   = CMP_WIDTH'(rnd_sum[PROD_WIDTH:FRACTION_BITS]);
		if (rnd_w > CMP_WIDTH'(PCLAMP)) begin
			mag_c = PCLAMP[QW-2:0];
		end else begin
			mag_c = rnd_w[QW-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4  <= mag_c;
			prod_s4 <= neg_s3 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		end
	end

endmodule

FILE: rtl/affb_lane.sv
module affb_lane import affb_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  word_t         entry [3],
	input  word_t         trans,
	input  opnd_t         ctr [3],
	input  opnd_t         ext [3],
	output sum_t          p_s5,
	output logic [SW-1:0] r_s5
);

	word_t trans_s3;
	word_t trans_s4;
	prod_t cp [3];
	prod_t ep [3];
	mag_t  cm [3];
	mag_t  em [3];

	// One rounded product per column for the centre and for the extent.
	for (genvar j = 0; j < 3; j++) begin : g_col
		affb_mulq u_ctr (
			.clk     (clk),
			.en      (en),
			.a       (entry[j]),
			.b       (ctr[j]),
			.prod_s4 (cp[j]),
			.mag_s4  (cm[j])
		);

		affb_mulq u_ext (
			.clk     (clk),
			.en      (en),
			.a       (entry[j]),
			.b       (ext[j]),
			.prod_s4 (ep[j]),
			.mag_s4  (em[j])
		);
	end

	// Translation rides along with the products.
	always_ff @(posedge clk) begin
		if (en) begin
			trans_s3 <= trans;
			trans_s4 <= trans_s3;
		end
	end

	// Centre image and the radius of the box along this axis.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= SW'(trans_s4) + SW'(cp[0]) + SW'(cp[1]) + SW'(cp[2]);
			r_s5 <= SW'(em[0]) + SW'(em[1]) + SW'(em[2]);
		end
	end

endmodule

FILE: rtl/affb_merge.sv
module affb_merge import affb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ctl_t          ctl_s5,
	input  sum_t          p [3],
	input  logic [SW-1:0] r [3],
	output logic          valid_q,
	output word_t         min_q [3],
	output word_t         max_q [3],
	output logic          unb_q
);

	word_t min_c [3];
	word_t max_c [3];

	// Combine each lane into saturated bounds; an unbounded box gives the extremes.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl_s5.unb) begin
				min_c[i] = VMIN;
				max_c[i] = VMAX;
			end else begin
				min_c[i] = sat(p[i] - $signed(r[i]));
				max_c[i] = sat(p[i] + $signed(r[i]));
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			min_q <= min_c;
			max_q <= max_c;
			unb_q <= ctl_s5.unb;
		end
	end

endmodule

FILE: rtl/affine_box_bounds.sv
// A box passes input, centre, product, rounding, lane sum and output registers.
// One item is taken every cycle while the result side takes transfers;
// the multiply pipeline (three lanes of six multipliers) sets this.
// A load takes effect for every box that follows it and produces no result.
// Reset clears all valid flags and sets the matrix to identity, zero translation.
module affine_box_bounds import affb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	affb_in_if.sink           item,
	affb_out_if.source        result
);

	logic          en;
	logic          out_valid;
	word_t         a_in [3];
	word_t         b_in [3];
	ctl_t          ctl_s2;
	ctl_t          ctl_s3;
	ctl_t          ctl_s4;
	ctl_t          ctl_s5;
	opnd_t         ctr_s2 [3];
	opnd_t         ext_s2 [3];
	word_t         mat [4][3];
	sum_t          p_s5 [3];
	logic [SW-1:0] r_s5 [3];
	word_t         min_q [3];
	word_t         max_q [3];
	logic          unb_q;

	// The whole pipeline advances unless a result waits untaken.
	assign en         = !out_valid || result.ready;
	assign item.ready = en;

	assign a_in[0] = item.a_x;
	assign a_in[1] = item.a_y;
	assign a_in[2] = item.a_z;
	assign b_in[0] = item.b_x;
	assign b_in[1] = item.b_y;
	assign b_in[2] = item.b_z;

	affb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (item.valid),
		.command  (item.command),
		.column   (item.column),
		.a        (a_in),
		.b        (b_in),
		.ctl_s2   (ctl_s2),
		.ctr_s2   (ctr_s2),
		.ext_s2   (ext_s2),
		.mat      (mat)
	);

	// One lane per world axis, each reading its row of the matrix.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		word_t row [3];

		assign row[0] = mat[0][i];
		assign row[1] = mat[1][i];
		assign row[2] = mat[2][i];

		affb_lane u_lane (
			.clk   (clk),
			.en    (en),
			.entry (row),
			.trans (mat[3][i]),
			.ctr   (ctr_s2),
			.ext   (ext_s2),
			.p_s5  (p_s5[i]),
			.r_s5  (r_s5[i])
		);
	end

	// Control pipeline that follows the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	affb_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s5  (ctl_s5),
		.p       (p_s5),
		.r       (r_s5),
		.valid_q (out_valid),
		.min_q   (min_q),
		.max_q   (max_q),
		.unb_q   (unb_q)
	);

	assign result.valid       = out_valid;
	assign result.world_min_x = min_q[0];
	assign result.world_min_y = min_q[1];
	assign result.world_min_z = min_q[2];
	assign result.world_max_x = max_q[0];
	assign result.world_max_y = max_q[1];
	assign result.world_max_z = max_q[2];
	assign result.unbounded   = unb_q;

	// An unbounded result carries the extreme values on every axis.
	a_unb_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.unbounded |->
			result.world_min_x == VMIN && result.world_min_y == VMIN &&
			result.world_min_z == VMIN && result.world_max_x == VMAX &&
			result.world_max_y == VMAX && result.world_max_z == VMAX)
		else $error("unbounded result without extreme bounds");

	// The lane radius is never negative, so bounds are always ordered.
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			result.world_min_x <= result.world_max_x &&
			result.world_min_y <= result.world_max_y &&
			result.world_min_z <= result.world_max_z)
		else $error("world minimum exceeds world maximum");

	// A stalled pipeline keeps the box waiting at the last lane stage.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && ctl_s5.valid |=> ctl_s5.valid)
		else $error("box lost in last lane stage during a stall");

	// A box reaches the output register only from the last lane stage.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl_s5.valid))
		else $error("result appeared without a box in the pipeline");

endmodule
